// ===== rtl/cppen_pkg.sv =====
// ----------------------------------------------------------------------------
// cppen_pkg
// Shared widths, constants and sideband types of the circle pair penetration
// pipeline.
// ----------------------------------------------------------------------------
package cppen_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned RadW   = 23;
  localparam int unsigned DiffW  = PosW + 1;
  localparam int unsigned MagW   = PosW;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned ProdW  = 2 * MagW;
  localparam int unsigned SqW    = 64;
  localparam int unsigned RootW  = SqW / 2;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned PenW   = 26;
  localparam int unsigned DistW  = 25;
  localparam int unsigned DirW   = 16;
  localparam int unsigned NumW   = 48;
  localparam int unsigned DenW   = 33;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned DivCmpW = DenW + QuoW;

  localparam logic [QuoW-1:0] DirPosMax = QuoW'(32767);
  localparam logic [QuoW-1:0] DirNegMax = QuoW'(32768);

  // sideband carried alongside the square root stages
  typedef struct packed {
    logic              sx;
    logic              sy;
    logic              coin;
    logic [PosW-1:0]   rsum;
    logic [MagW-1:0]   nx;
    logic [MagW-1:0]   ny;
  } cppen_sq_side_t;

  // sideband carried alongside the divider stages
  typedef struct packed {
    logic              sx;
    logic              sy;
    logic              coin;
    logic [PenW-1:0]   pen;
  } cppen_dv_side_t;

endpackage

// ===== rtl/cppen_isqrt.sv =====
// ----------------------------------------------------------------------------
// cppen_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module cppen_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cppen_pkg::SqW-1:0]  rad_i,
  output logic [cppen_pkg::RootW-1:0] root_o
);
  import cppen_pkg::*;

  logic [SqW-1:0]   rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [SqW-1:0]   rad_d  [RootW];
  logic [RemW-1:0]  rem_d  [RootW];
  logic [RootW-1:0] root_d [RootW];

  // one restoring step per stage: bring down two radicand bits, try a root bit
  always_comb begin
    logic [SqW-1:0]   rad_s;
    logic [RemW-1:0]  rem_s;
    logic [RootW-1:0] root_s;
    logic [RemW-1:0]  rem2;
    logic [RemW-1:0]  trial;
    for (int i = 0; i < RootW; i++) begin
      if (i == 0) begin
        rad_s  = rad_i;
        rem_s  = '0;
        root_s = '0;
      end else begin
        rad_s  = rad_q[i-1];
        rem_s  = rem_q[i-1];
        root_s = root_q[i-1];
      end
      rem2  = {rem_s[RemW-3:0], rad_s[SqW-1 -: 2]};
      trial = RemW'({root_s, 2'b01});
      rad_d[i] = {rad_s[SqW-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_d[i]  = rem2 - trial;
        root_d[i] = {root_s[RootW-2:0], 1'b1};
      end else begin
        rem_d[i]  = rem2;
        root_d[i] = {root_s[RootW-2:0], 1'b0};
      end
    end
  end

  // advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < RootW; i++) begin
        rad_q[i]  <= rad_d[i];
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

// ===== rtl/cppen_div.sv =====
// ----------------------------------------------------------------------------
// cppen_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module cppen_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [cppen_pkg::NumW-1:0] num_i,
  input  logic [cppen_pkg::DenW-1:0] den_i,
  output logic [cppen_pkg::QuoW-1:0] quo_o
);
  import cppen_pkg::*;

  logic [NumW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic [NumW-1:0] rem_d [QuoW];
  logic [QuoW-1:0] quo_d [QuoW];

  // stage i settles quotient bit QuoW-1-i
  always_comb begin
    logic [NumW-1:0]    rem_s;
    logic [DenW-1:0]    den_s;
    logic [QuoW-1:0]    quo_s;
    logic [DivCmpW-1:0] sh;
    for (int i = 0; i < QuoW; i++) begin
      if (i == 0) begin
        rem_s = num_i;
        den_s = den_i;
        quo_s = '0;
      end else begin
        rem_s = rem_q[i-1];
        den_s = den_q[i-1];
        quo_s = quo_q[i-1];
      end
      sh = DivCmpW'(den_s) << (QuoW - 1 - i);
      quo_d[i] = quo_s;
      if (DivCmpW'(rem_s) >= sh) begin
        rem_d[i] = rem_s - sh[NumW-1:0];
        quo_d[i][QuoW-1-i] = 1'b1;
      end else begin
        rem_d[i] = rem_s;
      end
    end
  end

  // advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QuoW; i++) begin
        rem_q[i] <= rem_d[i];
        den_q[i] <= (i == 0) ? den_i : den_q[i-1];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

// ===== rtl/circle_pair_penetration_core.sv =====
// ----------------------------------------------------------------------------
// circle_pair_penetration_core
// Penetration depth, overlap flag and contact normal of two circles.
// ----------------------------------------------------------------------------
// Usage: the input channel (valid_i / stall_o) takes one beat holding both
// centres and both radii in Q12.12. The output channel (valid_o / stall_i)
// gives one beat per input beat, in order: penetration (Q14.12), the overlap
// flag, the unit normal from A toward B in Q1.15 and the coincident flag.
// Throughput is one beat per cycle while stall_i does not hold the output.
// Stages: five front (difference, magnitude, normalise, square, sum), 32
// square root (one root bit each), one forming the quotient operands, 17
// divider (one quotient bit each) and the output register.
// The whole pipeline advances as one; when the output beat waits under
// stall_i the pipeline holds and stall_o rises, so nothing is lost or
// repeated. Reset clears every valid bit; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module circle_pair_penetration_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [cppen_pkg::PosW-1:0] pos_a_x_i,
  input  logic signed [cppen_pkg::PosW-1:0] pos_a_y_i,
  input  logic signed [cppen_pkg::PosW-1:0] pos_b_x_i,
  input  logic signed [cppen_pkg::PosW-1:0] pos_b_y_i,
  input  logic [cppen_pkg::RadW-1:0]    radius_a_i,
  input  logic [cppen_pkg::RadW-1:0]    radius_b_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [cppen_pkg::PenW-1:0] penetration_o,
  output logic                          overlapping_o,
  output logic signed [cppen_pkg::DirW-1:0] dir_x_o,
  output logic signed [cppen_pkg::DirW-1:0] dir_y_o,
  output logic                          coincident_o
);
  import cppen_pkg::*;

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // stage 1: differences and radius sum
  logic                    v1_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic [PosW-1:0]         rs1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= DiffW'(pos_b_x_i) - DiffW'(pos_a_x_i);
      dy_q  <= DiffW'(pos_b_y_i) - DiffW'(pos_a_y_i);
      rs1_q <= PosW'(radius_a_i) + PosW'(radius_b_i);
    end
  end

  // stage 2: magnitudes, signs, coincidence
  logic            v2_q, sx2_q, sy2_q, coin2_q;
  logic [MagW-1:0] ux2_q, uy2_q;
  logic [PosW-1:0] rs2_q;
  logic [DiffW-1:0] ax_d, ay_d;

  always_comb begin
    ax_d = dx_q[DiffW-1] ? DiffW'(-dx_q) : DiffW'(dx_q);
    ay_d = dy_q[DiffW-1] ? DiffW'(-dy_q) : DiffW'(dy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx2_q   <= dx_q[DiffW-1];
      sy2_q   <= dy_q[DiffW-1];
      coin2_q <= (dx_q == '0) && (dy_q == '0);
      ux2_q   <= ax_d[MagW-1:0];
      uy2_q   <= ay_d[MagW-1:0];
      rs2_q   <= rs1_q;
    end
  end

  // stage 3: normalise the larger magnitude to bit 23
  logic            v3_q, sx3_q, sy3_q, coin3_q;
  logic [MagW-1:0] ux3_q, uy3_q, nx3_q, ny3_q;
  logic [PosW-1:0] rs3_q;
  logic [MagW-1:0] mx_d;
  logic [ShiftW-1:0] k_d;

  always_comb begin
    mx_d = (ux2_q > uy2_q) ? ux2_q : uy2_q;
    k_d  = '0;
    for (int i = 0; i < MagW; i++) begin
      if (mx_d[i]) begin
        k_d = ShiftW'(MagW - 1 - i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx3_q   <= sx2_q;
      sy3_q   <= sy2_q;
      coin3_q <= coin2_q;
      ux3_q   <= ux2_q;
      uy3_q   <= uy2_q;
      nx3_q   <= ux2_q << k_d;
      ny3_q   <= uy2_q << k_d;
      rs3_q   <= rs2_q;
    end
  end

  // stage 4: squares
  logic             v4_q;
  logic [ProdW-1:0] px_q, py_q, pnx_q, pny_q;
  cppen_sq_side_t   side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= ProdW'(ux3_q) * ProdW'(ux3_q);
      py_q  <= ProdW'(uy3_q) * ProdW'(uy3_q);
      pnx_q <= ProdW'(nx3_q) * ProdW'(nx3_q);
      pny_q <= ProdW'(ny3_q) * ProdW'(ny3_q);
      side4_q <= '{sx: sx3_q, sy: sy3_q, coin: coin3_q, rsum: rs3_q,
                   nx: nx3_q, ny: ny3_q};
    end
  end

  // stage 5: sums of squares, scaled by 2^14 for the root
  logic           v5_q;
  logic [SqW-1:0] rad_dist_q, rad_norm_q;
  cppen_sq_side_t side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_dist_q <= (SqW'(px_q) + SqW'(py_q)) << 14;
      rad_norm_q <= (SqW'(pnx_q) + SqW'(pny_q)) << 14;
      side5_q    <= side4_q;
    end
  end

  // square root stages, sideband delayed alongside
  logic [RootW-1:0] root_dist, root_norm;
  logic [RootW-1:0] sq_vld_q;
  cppen_sq_side_t   sq_side_q [RootW];

  cppen_isqrt u_sqrt_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_dist_q),
    .root_o (root_dist)
  );

  cppen_isqrt u_sqrt_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_norm_q),
    .root_o (root_norm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else if (en) begin
      sq_vld_q <= {sq_vld_q[RootW-2:0], v5_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < RootW; i++) begin
        sq_side_q[i] <= (i == 0) ? side5_q : sq_side_q[i-1];
      end
    end
  end

  // quotient operands and penetration
  cppen_sq_side_t sqo;
  logic [DistW-1:0] dist_d;
  logic           vp_q;
  logic [NumW-1:0] numx_q, numy_q;
  logic [DenW-1:0] den_q;
  cppen_dv_side_t sidep_q;

  assign sqo    = sq_side_q[RootW-1];
  assign dist_d = root_dist[RootW-1 -: DistW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= sq_vld_q[RootW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q  <= (NumW'(sqo.nx) << 23) + NumW'(root_norm);
      numy_q  <= (NumW'(sqo.ny) << 23) + NumW'(root_norm);
      den_q   <= {root_norm, 1'b0};
      sidep_q <= '{sx: sqo.sx, sy: sqo.sy, coin: sqo.coin,
                   pen: PenW'(sqo.rsum) - PenW'(dist_d)};
    end
  end

  // divider stages, sideband delayed alongside
  logic [QuoW-1:0] quo_x, quo_y;
  logic [QuoW-1:0] dv_vld_q;
  cppen_dv_side_t  dv_side_q [QuoW];

  cppen_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numx_q),
    .den_i (den_q),
    .quo_o (quo_x)
  );

  cppen_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numy_q),
    .den_i (den_q),
    .quo_o (quo_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en) begin
      dv_vld_q <= {dv_vld_q[QuoW-2:0], vp_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < QuoW; i++) begin
        dv_side_q[i] <= (i == 0) ? sidep_q : dv_side_q[i-1];
      end
    end
  end

  // output register: saturate, apply sign, drop direction when coincident
  cppen_dv_side_t dvo;
  logic [QuoW-1:0] cx_d, cy_d;
  logic [DirW-1:0] ox_d, oy_d;

  assign dvo = dv_side_q[QuoW-1];

  always_comb begin
    if (dvo.sx) begin
      cx_d = (quo_x > DirNegMax) ? DirNegMax : quo_x;
      ox_d = DirW'(-cx_d);
    end else begin
      cx_d = (quo_x > DirPosMax) ? DirPosMax : quo_x;
      ox_d = cx_d[DirW-1:0];
    end
    if (dvo.sy) begin
      cy_d = (quo_y > DirNegMax) ? DirNegMax : quo_y;
      oy_d = DirW'(-cy_d);
    end else begin
      cy_d = (quo_y > DirPosMax) ? DirPosMax : quo_y;
      oy_d = cy_d[DirW-1:0];
    end
    if (dvo.coin) begin
      ox_d = '0;
      oy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= dv_vld_q[QuoW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      penetration_o <= dvo.pen;
      overlapping_o <= !dvo.pen[PenW-1];
      dir_x_o       <= ox_d;
      dir_y_o       <= oy_d;
      coincident_o  <= dvo.coin;
    end
  end

`ifndef SYNTHESIS
  a_coin_dir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && coincident_o |-> dir_x_o == '0 && dir_y_o == '0)
    else $error("coincident beat with nonzero direction");

  a_coin_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && coincident_o |-> overlapping_o)
    else $error("coincident beat not flagged as overlapping");

  a_dir_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !coincident_o |-> dir_x_o != '0 || dir_y_o != '0)
    else $error("distinct centres gave a zero direction");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(sq_vld_q) && $stable(dv_vld_q))
    else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives circle pairs into circle_pair_penetration_core with random gaps and
// random output stalls, predicts penetration, overlap, contact normal and the
// coincident flag for every accepted beat, and compares results in order.
// ----------------------------------------------------------------------------
module testbench;

  import cppen_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] ax;
    logic [PosW-1:0] ay;
    logic [PosW-1:0] bx;
    logic [PosW-1:0] by;
    logic [RadW-1:0] ra;
    logic [RadW-1:0] rb;
  } pair_t;

  typedef struct packed {
    logic [PenW-1:0] pen;
    logic            ovl;
    logic [DirW-1:0] dx;
    logic [DirW-1:0] dy;
    logic            coin;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic signed [PosW-1:0] pos_a_x_i = '0, pos_a_y_i = '0, pos_b_x_i = '0, pos_b_y_i = '0;
  logic [RadW-1:0] radius_a_i = '0, radius_b_i = '0;
  logic stall_o, valid_o, overlapping_o, coincident_o;
  logic signed [PenW-1:0] penetration_o;
  logic signed [DirW-1:0] dir_x_o, dir_y_o;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int       mismatches = 0;
  bit       stim_done = 1'b0;

  circle_pair_penetration_core uut (.*);

  always #5 clk_i = ~clk_i;

  // floor of the square root, one bit per pass
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // one Q1.15 normal component, rounded half away from zero and clamped
  function automatic logic [DirW-1:0] normal_part(logic [63:0] mag, logic neg,
                                                  logic [63:0] q);
    logic [63:0] r;
    r = (2 * (mag << 22) + q) / (2 * q);
    if (neg) begin
      if (r > 32768) r = 32768;
      return DirW'(-r);
    end
    if (r > 32767) r = 32767;
    return DirW'(r);
  endfunction

  function automatic contact_t contact_of(pair_t p);
    contact_t c;
    longint dxs, dys, pen;
    logic [63:0] ux, uy, m, nux, nuy, q, cdist;
    int k;
    dxs = longint'($signed(p.bx)) - longint'($signed(p.ax));
    dys = longint'($signed(p.by)) - longint'($signed(p.ay));
    ux = dxs < 0 ? -dxs : dxs;
    uy = dys < 0 ? -dys : dys;
    cdist = root_floor(ux * ux + uy * uy);
    pen = longint'(p.ra) + longint'(p.rb) - longint'(cdist);
    c.pen = PenW'(pen);
    c.ovl = pen >= 0;
    c.coin = (ux == 0) && (uy == 0);
    c.dx = '0;
    c.dy = '0;
    if (!c.coin) begin
      m = ux > uy ? ux : uy;
      k = 0;
      while (((m << k) >> (PosW - 1)) == 0) k++;
      nux = ux << k;
      nuy = uy << k;
      q = root_floor((nux * nux + nuy * nuy) << 14);
      c.dx = normal_part(nux, dxs < 0, q);
      c.dy = normal_part(nuy, dys < 0, q);
    end
    return c;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    logic [159:0] raw;
    int mode;
    mode = $urandom_range(0, 5);
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(pair_t)-1:0];
    case (mode) inside
      // near neighbours, so overlaps occur often
      0, 1: begin
        p.bx = p.ax + PosW'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
        p.by = p.ay + PosW'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
        p.ra = RadW'($urandom_range(0, 1 << 14));
        p.rb = RadW'($urandom_range(0, 1 << 14));
      end
      // axis aligned or coincident, sometimes neither
      2: begin
        if ($urandom_range(0, 1)) p.bx = p.ax;
        if ($urandom_range(0, 2) == 0) p.by = p.ay;
      end
      // tiny offsets exercise the normalising shift
      3: begin
        p.bx = p.ax + PosW'($signed($urandom_range(0, 6)) - 3);
        p.by = p.ay + PosW'($signed($urandom_range(0, 6)) - 3);
      end
      default: ;
    endcase
    return p;
  endfunction

  // fill the queue: directed corners first, then random pairs
  initial begin
    pair_t p;
    logic [PosW-1:0] mx, mn;
    mx = {1'b0, {(PosW-1){1'b1}}};
    mn = {1'b1, {(PosW-1){1'b0}}};
    pending_pairs.push_back('{mn, mn, mx, mx, '1, '1});
    pending_pairs.push_back('{mx, mx, mn, mn, '0, '0});
    pending_pairs.push_back('{mn, mx, mx, mn, '1, '0});
    pending_pairs.push_back('{mx, mn, mn, mx, '0, '1});
    pending_pairs.push_back('{'0, '0, '0, '0, '0, '0});
    pending_pairs.push_back('{mx, mx, mx, mx, '1, '1});
    pending_pairs.push_back('{mn, mn, mn, mn, '0, '0});
    pending_pairs.push_back('{'0, '0, 24'd1, '0, '0, '0});
    pending_pairs.push_back('{'0, '0, '1, '0, '0, '0});
    pending_pairs.push_back('{'0, '0, '0, 24'd1, '0, '0});
    pending_pairs.push_back('{'0, '0, '0, '1, '0, '0});
    pending_pairs.push_back('{'0, '0, 24'd1, 24'd1, '0, '0});
    pending_pairs.push_back('{'0, '0, '1, '1, '0, '0});
    pending_pairs.push_back('{'0, '0, 24'd4096, '0, 23'd2048, 23'd2048});
    pending_pairs.push_back('{'0, '0, 24'd4096, '0, 23'd2048, 23'd2047});
    pending_pairs.push_back('{'0, '0, 24'd3, 24'd4, '0, 23'd5});
    pending_pairs.push_back('{'0, '0, mn, '0, '0, '0});
    pending_pairs.push_back('{'0, '0, '0, mn, '0, '0});
    pending_pairs.push_back('{24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555,
                              23'h2aaaaa, 23'h555555});
    repeat (1850) begin
      p = random_pair();
      pending_pairs.push_back(p);
    end
  end

  // driver: hold a beat until accepted, then wait a random gap
  int gap = 0;
  always @(posedge clk_i) begin
    pair_t p;
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        expected_contacts.push_back(contact_of({pos_a_x_i, pos_a_y_i, pos_b_x_i,
                                                pos_b_y_i, radius_a_i, radius_b_i}));
      end
      if (!valid_i || !stall_o) begin
        if (gap > 0) begin
          gap <= gap - 1;
          valid_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          p = pending_pairs.pop_front();
          {pos_a_x_i, pos_a_y_i, pos_b_x_i, pos_b_y_i, radius_a_i, radius_b_i} <= p;
          valid_i <= 1'b1;
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end else begin
          valid_i <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // monitor: check each accepted result beat, draw random stalls
  int hold = 0;
  always @(posedge clk_i) begin
    contact_t e;
    int wait_n;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (expected_contacts.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          e = expected_contacts.pop_front();
          if (penetration_o !== e.pen)
            report_mismatch("penetration", penetration_o, $signed(e.pen));
          if (overlapping_o !== e.ovl) report_mismatch("overlapping", overlapping_o, e.ovl);
          if (dir_x_o !== e.dx) report_mismatch("dir_x", dir_x_o, $signed(e.dx));
          if (dir_y_o !== e.dy) report_mismatch("dir_y", dir_y_o, $signed(e.dy));
          if (coincident_o !== e.coin) report_mismatch("coincident", coincident_o, e.coin);
        end
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        hold <= (wait_n > 0) ? wait_n - 1 : 0;
        stall_i <= (wait_n > 0);
      end else if (hold > 0) begin
        hold <= hold - 1;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_contacts.size() == 0);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // give up after a generous bound
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
